// ===== sv/wma_pkg.sv =====
// wma_pkg: shared constants for the windowed moving average unit.
// No dependencies; used by every module under sv/.
`timescale 1ns / 1ps
`default_nettype none
package wma_pkg;

  // Default configuration of the window
  localparam int DEF_WINDOW       = 128;
  localparam int DEF_SAMPLE_WIDTH = 32;

  // Fixed port widths
  localparam int IN_WIDTH   = 32;
  localparam int OUT_WIDTH  = 32;
  localparam int FILL_WIDTH = 8;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

// ===== sv/wma_front.sv =====
// wma_front: accepts samples, keeps the sample ring, pointer, running sum and fill count.
// Depends on wma_pkg; hands one entry per sample to the queue.
`timescale 1ns / 1ps
`default_nettype none
module wma_front #(
  parameter int WINDOW       = wma_pkg::DEF_WINDOW,
  parameter int SAMPLE_WIDTH = wma_pkg::DEF_SAMPLE_WIDTH,
  parameter int CNT_W        = $clog2(WINDOW + 1),
  parameter int SUM_W        = SAMPLE_WIDTH + CNT_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [wma_pkg::IN_WIDTH-1:0]  sample,
  output logic                               q_push,
  input  wire logic                          q_full,
  output logic [SUM_W-1:0]                   q_sum,
  output logic [CNT_W-1:0]                   q_cnt,
  output logic [SAMPLE_WIDTH-1:0]            q_sample
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic FR_IDLE = 1'b0;
  localparam logic FR_UPD  = 1'b1;

  logic                    state;
  logic [PTR_W-1:0]        wp;
  logic [CNT_W-1:0]        count;
  logic [SUM_W-1:0]        sum;
  logic [SAMPLE_WIDTH-1:0] fresh;
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic [SAMPLE_WIDTH-1:0] ring [WINDOW];

  logic                    accept;
  logic                    ring_full;
  logic [SAMPLE_WIDTH-1:0] stale;
  logic [SUM_W-1:0]        sum_next;
  logic [CNT_W-1:0]        count_next;

  assign full   = (state != FR_IDLE) || q_full;
  assign accept = push && !full;

  // entries not yet written on the first pass read as zero
  assign ring_full  = (count == CNT_W'(WINDOW));
  assign stale      = ring_full ? rd_data : '0;
  assign sum_next   = sum - SUM_W'(stale) + SUM_W'(fresh);
  assign count_next = ring_full ? count : count + CNT_W'(1);

  assign q_push   = (state == FR_UPD);
  assign q_sum    = sum_next;
  assign q_cnt    = count_next;
  assign q_sample = fresh;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= ring[wp];
      fresh   <= SAMPLE_WIDTH'(sample);
    end
    if (state == FR_UPD) begin
      ring[wp] <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      wp    <= '0;
      count <= '0;
      sum   <= '0;
    end else begin
      unique case (state)
        FR_IDLE: begin
          if (accept) begin
            state <= FR_UPD;
          end
        end
        FR_UPD: begin
          sum   <= sum_next;
          count <= count_next;
          wp    <= (wp == PTR_W'(WINDOW - 1)) ? '0 : wp + PTR_W'(1);
          state <= FR_IDLE;
        end
        default: state <= FR_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/wma_fifo.sv =====
// wma_fifo: short queue that decouples the front from the divider back end.
// Depends on wma_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none
module wma_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int DEPTH = wma_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] used;
  logic             do_wr;
  logic             do_rd;

  assign full    = (used == CNT_W'(DEPTH));
  assign empty   = (used == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        used <= used + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        used <= used - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/wma_back.sv =====
// wma_back: bit-serial restoring divider (sum / count) and the result register.
// Depends on wma_pkg; takes entries from wma_fifo.
`timescale 1ns / 1ps
`default_nettype none
module wma_back #(
  parameter int SAMPLE_WIDTH = wma_pkg::DEF_SAMPLE_WIDTH,
  parameter int CNT_W        = 8,
  parameter int SUM_W        = SAMPLE_WIDTH + CNT_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           q_empty,
  output logic                                q_pop,
  input  wire logic [SUM_W-1:0]               q_sum,
  input  wire logic [CNT_W-1:0]               q_cnt,
  input  wire logic [SAMPLE_WIDTH-1:0]        q_sample,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [wma_pkg::OUT_WIDTH-1:0]       average,
  output logic [wma_pkg::OUT_WIDTH-1:0]       last_sample,
  output logic [wma_pkg::FILL_WIDTH-1:0]      filled
);

  localparam int IT_W = $clog2(SUM_W + 1);
  localparam logic [1:0] BK_IDLE = 2'd0;
  localparam logic [1:0] BK_DIV  = 2'd1;
  localparam logic [1:0] BK_HOLD = 2'd2;

  logic [1:0]              state;
  logic [IT_W-1:0]         iter;
  logic [SUM_W-1:0]        dvd;
  logic [CNT_W-1:0]        dsr;
  logic [CNT_W-1:0]        rem;
  logic [SAMPLE_WIDTH-1:0] samp;
  logic                    out_valid;

  logic [CNT_W:0]          trial;
  logic                    fits;
  logic [CNT_W:0]          diff;
  logic                    out_free;

  assign trial    = {rem, dvd[SUM_W-1]};
  assign fits     = (trial >= {1'b0, dsr});
  assign diff     = trial - {1'b0, dsr};
  assign out_free = !out_valid || pop;
  assign q_pop    = (state == BK_IDLE) && !q_empty;
  assign empty    = !out_valid;

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dvd  <= q_sum;
      dsr  <= q_cnt;
      samp <= q_sample;
      rem  <= '0;
    end else if (state == BK_DIV) begin
      rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      dvd <= {dvd[SUM_W-2:0], fits};
    end
    if (state == BK_HOLD && out_free) begin
      average     <= wma_pkg::OUT_WIDTH'(dvd);
      last_sample <= wma_pkg::OUT_WIDTH'(samp);
      filled      <= wma_pkg::FILL_WIDTH'(dsr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      // in BK_HOLD a pop is followed straight by the next result
      if (pop && out_valid && state != BK_HOLD) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        BK_IDLE: begin
          if (q_pop) begin
            iter  <= IT_W'(SUM_W);
            state <= BK_DIV;
          end
        end
        BK_DIV: begin
          iter <= iter - IT_W'(1);
          if (iter == IT_W'(1)) begin
            state <= BK_HOLD;
          end
        end
        BK_HOLD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= BK_IDLE;
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/windowed_moving_average_unit.sv =====
// windowed_moving_average_unit: top level of the boxcar moving average.
// Depends on wma_pkg, wma_front, wma_fifo and wma_back.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel   ports                                  transaction moves on
//  --------  -------------------------------------  -------------------------
//  input     push, full, sample[31:0]               push && !full
//  result    empty, pop, average[31:0],             pop && !empty
//            last_sample[31:0], filled[7:0]
//
// Front: each sample goes through a ring read, then a sum/ring update, and full
// stays high meanwhile. The back divides the running sum by the fill count one
// quotient bit per cycle and takes no new queue entry until its result has gone to
// the output register, so sustained throughput is set by the serial divider.
// Reset (rst, synchronous) clears pointer, sum, fill count and all handshake state;
// no clearing pass is needed, since first-pass ring reads are masked by fill count.
// A stalled result consumer backs up the divider, then the queue, then full.
module windowed_moving_average_unit #(
  parameter int WINDOW       = wma_pkg::DEF_WINDOW,
  parameter int SAMPLE_WIDTH = wma_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [wma_pkg::IN_WIDTH-1:0]   sample,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [wma_pkg::OUT_WIDTH-1:0]       average,
  output logic [wma_pkg::OUT_WIDTH-1:0]       last_sample,
  output logic [wma_pkg::FILL_WIDTH-1:0]      filled
);

  // fill count holds 0..WINDOW; the sum needs that many extra bits over a sample
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + CNT_W;
  localparam int Q_W   = SUM_W + CNT_W + SAMPLE_WIDTH;

  // front -> queue
  logic                    f_push;
  logic                    f_full;
  logic [SUM_W-1:0]        f_sum;
  logic [CNT_W-1:0]        f_cnt;
  logic [SAMPLE_WIDTH-1:0] f_sample;

  // queue -> back
  logic                    b_empty;
  logic                    b_pop;
  logic [Q_W-1:0]          b_data;

  wma_front #(
    .WINDOW       (WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .sample   (sample),
    .q_push   (f_push),
    .q_full   (f_full),
    .q_sum    (f_sum),
    .q_cnt    (f_cnt),
    .q_sample (f_sample)
  );

  // entry layout: {sum, count, sample}
  wma_fifo #(
    .W (Q_W)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data ({f_sum, f_cnt, f_sample}),
    .full    (f_full),
    .rd      (b_pop),
    .rd_data (b_data),
    .empty   (b_empty)
  );

  wma_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CNT_W        (CNT_W),
    .SUM_W        (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (b_empty),
    .q_pop       (b_pop),
    .q_sum       (b_data[Q_W-1 -: SUM_W]),
    .q_cnt       (b_data[SAMPLE_WIDTH +: CNT_W]),
    .q_sample    (b_data[SAMPLE_WIDTH-1:0]),
    .empty       (empty),
    .pop         (pop),
    .average     (average),
    .last_sample (last_sample),
    .filled      (filled)
  );

endmodule
`default_nettype wire
